/* sv/ild_pkg.sv */
// Shared types and constants for the x86-64 instruction length decoder.
// No dependencies; used by ild_front, ild_queue, ild_back, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package ild_pkg;

  // Bytes in one instruction window.
  localparam int WINDOW_BYTES = 16;
  // Longest length that is reported; anything above it reads as not recognized.
  localparam int LEN_LIMIT = (WINDOW_BYTES < 15) ? WINDOW_BYTES : 15;

  // Prefix and opcode bytes that the classifier looks for.
  localparam logic [7:0] OPSIZE_PREFIX = 8'h66;
  localparam logic [3:0] REX_HIGH      = 4'h4;
  localparam logic [7:0] ESCAPE_0F     = 8'h0F;
  localparam logic [7:0] NOP_1F        = 8'h1F;

  // How the back end finishes the length of an instruction.
  typedef enum logic [1:0] {
    KIND_FIXED,  // length is the base alone
    KIND_MODRM,  // base plus the bytes taken by ModRM and its addressing extras
    KIND_BAD     // not in the supported subset
  } kind_t;

  // Classification handed from the front end to the back end.
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  base;      // prefixes, opcode and immediate bytes
    logic [7:0]  modrm;     // ModRM byte, meaningful for KIND_MODRM
    logic [2:0]  sib_base;  // base field of the byte after ModRM
  } cls_t;

endpackage

`default_nettype wire

/* sv/ild_front.sv */
// Front end of the instruction length decoder: takes a window, finds the prefixes and
// opcode, and registers a classification. Depends on ild_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ild_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [127:0]  s_axis_tdata,   // [63:0] bytes_low, [127:64] bytes_high
  output logic               cls_valid,
  input  wire logic          cls_ready,
  output ild_pkg::cls_t      cls
);

  // Only the first six bytes can bear on the length: two prefixes, the opcode, the
  // second opcode byte, ModRM and SIB.
  logic [7:0]     win [6];
  logic           opsize;
  logic [7:0]     first;
  logic           rex;
  logic           rexw;
  logic [1:0]     pos;
  logic [2:0]     idx0;
  logic [7:0]     op;
  logic [7:0]     nb1;
  logic [7:0]     nb2;
  logic [7:0]     nb3;
  logic [2:0]     reg_f;
  logic [3:0]     p4;
  logic [3:0]     immv;
  ild_pkg::cls_t  cls_next;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win[i] = s_axis_tdata[8*i +: 8];
    end
  end

  assign opsize = (win[0] == ild_pkg::OPSIZE_PREFIX);
  assign first  = opsize ? win[1] : win[0];
  assign rex    = (first[7:4] == ild_pkg::REX_HIGH);
  assign rexw   = rex && first[3];
  assign pos    = {1'b0, opsize} + {1'b0, rex};
  assign idx0   = {1'b0, pos};
  assign op     = win[idx0];
  assign nb1    = win[idx0 + 3'd1];
  assign nb2    = win[idx0 + 3'd2];
  assign nb3    = win[idx0 + 3'd3];
  assign reg_f  = nb1[5:3];
  assign p4     = {2'b00, pos};
  assign immv   = (opsize && !rexw) ? 4'd2 : 4'd4;

  always_comb begin
    cls_next.kind     = ild_pkg::KIND_BAD;
    cls_next.base     = '0;
    cls_next.modrm    = nb1;
    cls_next.sib_base = nb2[2:0];
    priority if ((op >= 8'h50 && op <= 8'h5F) || op == 8'h90 || op == 8'hC3 ||
                 op == 8'hCC) begin
      cls_next.kind = ild_pkg::KIND_FIXED;
      cls_next.base = p4 + 4'd1;
    end else if ((op >= 8'hB0 && op <= 8'hB7) || op == 8'h3C || op == 8'h34 ||
                 op == 8'hA8 || op == 8'hEB || op == 8'h74 || op == 8'h75 ||
                 op == 8'h77 || op == 8'h7C) begin
      cls_next.kind = ild_pkg::KIND_FIXED;
      cls_next.base = p4 + 4'd2;
    end else if (op >= 8'hB8 && op <= 8'hBF) begin
      cls_next.kind = ild_pkg::KIND_FIXED;
      cls_next.base = p4 + 4'd1 + (rexw ? 4'd8 : immv);
    end else if (op == 8'h35 || op == 8'h3D || op == 8'hA9) begin
      cls_next.kind = ild_pkg::KIND_FIXED;
      cls_next.base = p4 + 4'd1 + immv;
    end else if (op == 8'hE8 || op == 8'hE9) begin
      cls_next.kind = ild_pkg::KIND_FIXED;
      cls_next.base = p4 + 4'd5;
    end else if (op == 8'hEA) begin
      cls_next.kind = ild_pkg::KIND_FIXED;
      cls_next.base = p4 + 4'd7;
    end else if ((op >= 8'h30 && op <= 8'h33) || op == 8'h39 || op == 8'h3B ||
                 op == 8'h84 || op == 8'h85 || (op >= 8'h88 && op <= 8'h8B)) begin
      cls_next.kind = ild_pkg::KIND_MODRM;
      cls_next.base = p4 + 4'd1;
    end else if (op == 8'h80 || op == 8'h83) begin
      if (reg_f == 3'd6 || reg_f == 3'd7) begin
        cls_next.kind = ild_pkg::KIND_MODRM;
        cls_next.base = p4 + 4'd2;
      end
    end else if (op == 8'h81) begin
      if (reg_f == 3'd6 || reg_f == 3'd7) begin
        cls_next.kind = ild_pkg::KIND_MODRM;
        cls_next.base = p4 + 4'd1 + immv;
      end
    end else if (op == 8'hC6) begin
      cls_next.kind = ild_pkg::KIND_MODRM;
      cls_next.base = p4 + 4'd2;
    end else if (op == 8'hC7) begin
      cls_next.kind = ild_pkg::KIND_MODRM;
      cls_next.base = p4 + 4'd1 + immv;
    end else if (op == 8'hF6) begin
      if (reg_f == 3'd0) begin
        cls_next.kind = ild_pkg::KIND_MODRM;
        cls_next.base = p4 + 4'd2;
      end
    end else if (op == 8'hF7) begin
      if (reg_f == 3'd0) begin
        cls_next.kind = ild_pkg::KIND_MODRM;
        cls_next.base = p4 + 4'd1 + immv;
      end
    end else if (op == ild_pkg::ESCAPE_0F) begin
      // Two-byte opcodes: the ModRM byte, where there is one, follows the second byte.
      if (nb1 == ild_pkg::NOP_1F || (nb1 >= 8'h90 && nb1 <= 8'h9F) ||
          nb1 == 8'hB6 || nb1 == 8'hBE || nb1 == 8'hC1) begin
        cls_next.kind     = ild_pkg::KIND_MODRM;
        cls_next.base     = p4 + 4'd2;
        cls_next.modrm    = nb2;
        cls_next.sib_base = nb3[2:0];
      end else if (nb1 >= 8'h80 && nb1 <= 8'h8F) begin
        cls_next.kind = ild_pkg::KIND_FIXED;
        cls_next.base = p4 + 4'd6;
      end else begin
        cls_next.kind = ild_pkg::KIND_FIXED;
        cls_next.base = p4 + 4'd2;
      end
    end else if (op == 8'hFF) begin
      if (reg_f == 3'd4 || reg_f == 3'd5) begin
        cls_next.kind = ild_pkg::KIND_MODRM;
        cls_next.base = p4 + 4'd1;
      end
    end else begin
      cls_next.kind = ild_pkg::KIND_BAD;
    end
  end

  assign s_axis_tready = !cls_valid || cls_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (s_axis_tready) begin
      cls_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      cls <= cls_next;
    end
  end

endmodule

`default_nettype wire

/* sv/ild_queue.sv */
// Two-entry queue of classifications between the front end and the back end.
// Depends on ild_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ild_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  ild_pkg::cls_t in_cls,
  output logic          out_valid,
  input  wire logic     out_ready,
  output ild_pkg::cls_t out_cls
);

  ild_pkg::cls_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cls   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      mem[wr_ptr] <= in_cls;
    end
  end

endmodule

`default_nettype wire

/* sv/ild_back.sv */
// Back end of the instruction length decoder: adds the ModRM addressing bytes to the
// base length, applies the length limit and registers the result. Depends on ild_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ild_back (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cls_valid,
  output logic          cls_ready,
  input  ild_pkg::cls_t cls,
  output logic          m_axis_tvalid,
  input  wire logic     m_axis_tready,
  output logic [7:0]    m_axis_tdata,   // [3:0] insn_length, [7:4] zero
  output logic          m_axis_tuser    // [0] recognized
);

  logic [1:0] md;
  logic [2:0] rm;
  logic [2:0] mlen;
  logic [4:0] total;
  logic [3:0] len_next;

  assign md = cls.modrm[7:6];
  assign rm = cls.modrm[2:0];

  always_comb begin
    mlen = 3'd1;
    if (md != 2'd3) begin
      if (rm == 3'd4) begin
        mlen = (md == 2'd0 && cls.sib_base == 3'd5) ? 3'd6 : 3'd2;
      end else if (md == 2'd0 && rm == 3'd5) begin
        mlen = 3'd5;
      end
      if (md == 2'd1) begin
        mlen = mlen + 3'd1;
      end else if (md == 2'd2) begin
        mlen = mlen + 3'd4;
      end
    end
  end

  always_comb begin
    total = {1'b0, cls.base};
    if (cls.kind == ild_pkg::KIND_MODRM) begin
      total = {1'b0, cls.base} + {2'b00, mlen};
    end
    if (cls.kind == ild_pkg::KIND_BAD || total > 5'(ild_pkg::LEN_LIMIT)) begin
      len_next = 4'd0;
    end else begin
      len_next = total[3:0];
    end
  end

  assign cls_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cls_ready) begin
      m_axis_tvalid <= cls_valid;
    end
    if (cls_valid && cls_ready) begin
      m_axis_tdata <= {4'b0000, len_next};
      m_axis_tuser <= (len_next != 4'd0);
    end
  end

endmodule

`default_nettype wire

/* sv/x86_64_instruction_length_decoder.sv */
// Top level of the x86-64 instruction length decoder: front end, queue and back end.
// Depends on ild_pkg, ild_front, ild_queue and ild_back.
//
// Usage: each input transaction carries a 16-byte window that begins at an x86-64
// instruction (s_axis_tdata, byte 0 in bits 7:0). For every input transaction the
// block returns exactly one output transaction, in order, with the instruction length
// in m_axis_tdata[3:0] and the recognized flag in m_axis_tuser; an instruction outside
// the supported subset, or longer than 15 bytes, gives length 0 and flag 0.
// Only the first six bytes of the window can change the result.
// Each classification passes through the front register, the queue and the output
// register in that order, and m_axis_tvalid rises when the output register is
// loaded. One transaction is taken per cycle, sustained, while m_axis_tready stays
// high; every stage keeps its own valid state and nothing iterates.
// When the receiver holds m_axis_tready low, the output register keeps its value, the
// two-entry queue fills and the front register then holds, so up to four transactions
// are taken before s_axis_tready drops. Nothing is lost or repeated across a stall.
// Reset (rst, synchronous, active high) empties every stage; s_axis_tready is high in
// the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module x86_64_instruction_length_decoder (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [127:0]  s_axis_tdata,   // [63:0] bytes_low, [127:64] bytes_high
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [3:0] insn_length, [7:4] zero
  output logic               m_axis_tuser    // [0] recognized
);

  // Front end to queue.
  logic          f_valid;
  logic          f_ready;
  ild_pkg::cls_t f_cls;
  // Queue to back end.
  logic          q_valid;
  logic          q_ready;
  ild_pkg::cls_t q_cls;

  ild_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cls_valid     (f_valid),
    .cls_ready     (f_ready),
    .cls           (f_cls)
  );

  // The queue lets the front end keep taking windows for a while when the receiver
  // stalls, and lets the back end drain while no new window arrives.
  ild_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cls    (f_cls),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cls   (q_cls)
  );

  ild_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cls_valid     (q_valid),
    .cls_ready     (q_ready),
    .cls           (q_cls),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* sv/ild_checker.sv */
// Port-level checks for the x86-64 instruction length decoder, bound to the top level.
// Depends on ild_pkg and x86_64_instruction_length_decoder.
`timescale 1ns / 1ps
`default_nettype none

module ild_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [7:0]   m_axis_tdata,
  input wire logic         m_axis_tuser
);

  // The flag and the length must agree.
  a_flag_matches_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[3:0] != 4'd0)))
    else $error("recognized flag disagrees with length");

  // Padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'd0))
    else $error("nonzero padding in output data");

  // No reported length exceeds the window limit.
  a_len_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[3:0]} <= 5'(ild_pkg::LEN_LIMIT)))
    else $error("length above limit");

  // Reset empties the pipeline and opens the input.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("output valid or input closed after reset");

  // A stalled result stays put.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output changed");

endmodule

bind x86_64_instruction_length_decoder ild_checker u_ild_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
